>>> rtl/core/lra_pkg.sv
// Package for the LRU register allocator.
// Holds sizes, request codes and the controller-to-datapath command type.
// No dependencies.
package lra_pkg;

    localparam int NUM_REGS  = 7;
    localparam int TAG_BITS  = 16;

    localparam int TAG_W     = 16;
    localparam int REG_NUM_W = 3;

    localparam int IDX_BITS  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int RANK_BITS = IDX_BITS;
    localparam int CNT_BITS  = $clog2(NUM_REGS + 1);
    localparam int REG_BITS  = CNT_BITS;

    localparam int S_DATA_W  = ((TAG_W + 7) / 8) * 8;
    localparam int M_DATA_W  = ((REG_NUM_W + 2 + 7) / 8) * 8;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef struct packed {
        logic accept;
    } lra_cmd_t;

endpackage

>>> rtl/core/lru_register_allocator.sv
// LRU register allocator, top level.
// Latency: a result appears in the cycle after its request beat is taken.
// Throughput: one request per cycle; the output register is refilled on the
// same edge it is drained, so only a stalled master side holds the input.
// Reset: synchronous on aresetn low; clears bindings, use count and output valid.
module lru_register_allocator
    import lra_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [15:0] temp_tag
    input  logic [0:0]          s_tuser,   // [0] op
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [2:0] reg_num, [3] found, [4] from_free
);

    lra_cmd_t             cmd;
    logic [REG_NUM_W-1:0] reg_num;
    logic                 found;
    logic                 from_free;

    lra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    lra_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .op        (s_tuser[0]),
        .temp_tag  (s_tdata[TAG_W-1:0]),
        .reg_num   (reg_num),
        .found     (found),
        .from_free (from_free)
    );

    assign m_tdata = M_DATA_W'({from_free, found, reg_num});

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted request produced no result");

    a_alloc_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == OP_ALLOC)) |=> (found && (reg_num != '0)))
        else $error("allocate did not return a register");

    a_miss_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !found) |-> ((reg_num == '0) && !from_free))
        else $error("read miss carries a register or fresh flag");

    a_fresh_is_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == OP_READ)) |=> !from_free)
        else $error("read reported a fresh register");

endmodule

>>> rtl/core/lra_ctrl.sv
// Handshake controller for the LRU register allocator.
// Tracks the output register and issues the accept command. Uses lra_pkg.
module lra_ctrl
    import lra_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output lra_cmd_t cmd
);

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } state_t;

    state_t state_reg;
    logic   accept;

    assign s_tready   = (state_reg == ST_EMPTY) || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign m_tvalid   = (state_reg == ST_FULL);
    assign cmd.accept = accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_EMPTY;
        end else begin
            unique case (state_reg)
                ST_EMPTY: begin
                    if (accept) begin
                        state_reg <= ST_FULL;
                    end
                end
                ST_FULL: begin
                    if (!accept && m_tready) begin
                        state_reg <= ST_EMPTY;
                    end
                end
                default: begin
                    state_reg <= ST_EMPTY;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/lra_datapath.sv
// Datapath of the LRU register allocator: tag store, recency ranks,
// use count and output register. Uses lra_pkg; driven by lra_ctrl.
module lra_datapath
    import lra_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lra_cmd_t             cmd,
    input  logic                 op,
    input  logic [TAG_W-1:0]     temp_tag,
    output logic [REG_NUM_W-1:0] reg_num,
    output logic                 found,
    output logic                 from_free
);

    logic [TAG_BITS-1:0]  tag_reg   [NUM_REGS];
    logic [NUM_REGS-1:0]  valid_reg;
    logic [RANK_BITS-1:0] rank_reg  [NUM_REGS];
    logic [CNT_BITS-1:0]  used_reg;

    logic [REG_NUM_W-1:0] reg_num_reg;
    logic                 found_reg;
    logic                 from_free_reg;

    logic [TAG_BITS-1:0]  tag_in;
    logic [NUM_REGS-1:0]  hit;
    logic                 hit_any;
    logic [IDX_BITS-1:0]  hit_idx;
    logic [IDX_BITS-1:0]  victim_idx;
    logic                 fresh;
    logic                 is_alloc;
    logic [IDX_BITS-1:0]  tgt_idx;
    logic [CNT_BITS-1:0]  tgt_rank;
    logic                 do_update;
    logic [REG_BITS-1:0]  result_reg;

    assign tag_in   = TAG_BITS'(temp_tag);
    assign is_alloc = (op_t'(op) == OP_ALLOC);
    assign fresh    = (used_reg < CNT_BITS'(NUM_REGS));

    always_comb begin
        hit_idx    = '0;
        victim_idx = '0;
        for (int i = NUM_REGS - 1; i >= 0; i--) begin
            hit[i] = valid_reg[i] && (tag_reg[i] == tag_in);
            if (hit[i]) begin
                hit_idx = IDX_BITS'(i);
            end
            if (valid_reg[i] && (rank_reg[i] == RANK_BITS'(NUM_REGS - 1))) begin
                victim_idx = IDX_BITS'(i);
            end
        end
        hit_any = |hit;
    end

    always_comb begin
        priority if (is_alloc && fresh) begin
            tgt_idx  = IDX_BITS'(used_reg);
            tgt_rank = used_reg;
        end else if (is_alloc) begin
            tgt_idx  = victim_idx;
            tgt_rank = CNT_BITS'(NUM_REGS - 1);
        end else begin
            tgt_idx  = hit_idx;
            tgt_rank = CNT_BITS'(rank_reg[hit_idx]);
        end
        do_update = cmd.accept && (is_alloc || hit_any);
        if (is_alloc || hit_any) begin
            result_reg = REG_BITS'(tgt_idx) + REG_BITS'(1);
        end else begin
            result_reg = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            used_reg  <= '0;
        end else if (do_update && is_alloc) begin
            valid_reg[tgt_idx] <= 1'b1;
            if (fresh) begin
                used_reg <= used_reg + CNT_BITS'(1);
            end
        end
    end

    // Promote the target to most recent; age the entries that were ahead of it.
    always_ff @(posedge aclk) begin
        if (do_update) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                if (IDX_BITS'(i) == tgt_idx) begin
                    rank_reg[i] <= '0;
                end else if (valid_reg[i] && (CNT_BITS'(rank_reg[i]) < tgt_rank)) begin
                    rank_reg[i] <= rank_reg[i] + RANK_BITS'(1);
                end
            end
            if (is_alloc) begin
                tag_reg[tgt_idx] <= tag_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            reg_num_reg   <= REG_NUM_W'(result_reg);
            found_reg     <= is_alloc || hit_any;
            from_free_reg <= is_alloc && fresh;
        end
    end

    assign reg_num   = reg_num_reg;
    assign found     = found_reg;
    assign from_free = from_free_reg;

endmodule
